// ----- hw/rtl/cfsd_pkg.sv -----
// cfsd_pkg: shared types and constants of the checksum frame sync decoder.
// No dependencies; cfsd_front, cfsd_queue, cfsd_back and the top unit use it.
`default_nettype none

package cfsd_pkg;

	localparam int unsigned FRAME_BYTES = 9;
	localparam int unsigned WIN_BYTES   = FRAME_BYTES - 1;
	localparam int unsigned FILL_W      = 4;
	localparam int unsigned LIMIT_W     = 11;
	localparam int unsigned POLL_CNT_W  = 12;

	localparam logic [FILL_W-1:0]  FILL_FULL        = FILL_W'(WIN_BYTES);
	localparam logic [LIMIT_W-1:0] POLL_LIMIT_RESET = 11'd1000;

	// operation codes of an input transaction
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_POLL = 1'b1;

	// result kinds
	localparam logic KIND_FRAME   = 1'b0;
	localparam logic KIND_TIMEOUT = 1'b1;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  frame_command;
		logic [7:0]  frame_value;
		logic [31:0] frame_epoch;
		logic [15:0] frame_ticks;
	} result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cfsd_in_if.sv -----
// cfsd_in_if: input channel (received byte or idle poll) with valid/ready.
// No dependencies.
`default_nettype none

interface cfsd_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] rx_byte;

	modport source (output valid, output operation, output rx_byte, input ready);
	modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cfsd_out_if.sv -----
// cfsd_out_if: result channel (decoded frame or read timeout) with valid/ready.
// No dependencies.
`default_nettype none

interface cfsd_out_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  frame_command;
	logic [7:0]  frame_value;
	logic [31:0] frame_epoch;
	logic [15:0] frame_ticks;

	modport source (output valid, output result_kind, output frame_command,
		output frame_value, output frame_epoch, output frame_ticks, input ready);
	modport sink (input valid, input result_kind, input frame_command,
		input frame_value, input frame_epoch, input frame_ticks, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cfsd_cfg_if.sv -----
// cfsd_cfg_if: configuration write channel for the idle poll limit register.
// No dependencies.
`default_nettype none

interface cfsd_cfg_if;
	logic        valid;
	logic        ready;
	logic [10:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cfsd_front.sv -----
// cfsd_front: accepts transactions, keeps the byte window, checksum and poll
// counter, and pushes results into the queue. Uses cfsd_pkg, cfsd_in_if, cfsd_cfg_if.
`default_nettype none

module cfsd_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	cfsd_in_if.sink               in_ch,
	cfsd_cfg_if.sink              cfg,
	input  wire logic             q_full,
	output logic                  push,
	output cfsd_pkg::result_t     push_data
);

	// last eight bytes, oldest at index 0
	cfsd_pkg::byte_t                      win_q [cfsd_pkg::WIN_BYTES];
	logic [cfsd_pkg::FILL_W-1:0]          fill_q;
	logic [cfsd_pkg::POLL_CNT_W-1:0]      poll_cnt_q;
	logic [cfsd_pkg::LIMIT_W-1:0]         limit_q;

	logic                                 accept;
	logic                                 is_byte;
	cfsd_pkg::byte_t                      sum;
	logic                                 match;
	logic [cfsd_pkg::POLL_CNT_W-1:0]      poll_inc;
	logic                                 timeout;

	assign in_ch.ready = !q_full;
	assign cfg.ready   = 1'b1;
	assign accept      = in_ch.valid && in_ch.ready;
	assign is_byte     = (in_ch.operation == cfsd_pkg::OP_BYTE);

	// frame bytes 1..7 summed mod 256, checked against the incoming byte 8
	always_comb begin
		sum = '0;
		for (int k = 1; k < cfsd_pkg::WIN_BYTES; k++) begin
			sum = sum + win_q[k];
		end
	end

	assign match    = (fill_q == cfsd_pkg::FILL_FULL) && (sum == in_ch.rx_byte);
	assign poll_inc = poll_cnt_q + 1'b1;
	assign timeout  = (poll_inc > {1'b0, limit_q});

	always_comb begin
		push_data = '0;
		if (is_byte) begin
			push_data.result_kind   = cfsd_pkg::KIND_FRAME;
			push_data.frame_command = win_q[0];
			push_data.frame_value   = win_q[1];
			push_data.frame_epoch   = {win_q[5], win_q[4], win_q[3], win_q[2]};
			push_data.frame_ticks   = {win_q[7], win_q[6]};
		end else begin
			push_data.result_kind = cfsd_pkg::KIND_TIMEOUT;
		end
	end

	assign push = accept && (is_byte ? match : timeout);

	always_ff @(posedge clk) begin
		if (accept && is_byte) begin
			for (int k = 0; k < cfsd_pkg::WIN_BYTES - 1; k++) begin
				win_q[k] <= win_q[k+1];
			end
			win_q[cfsd_pkg::WIN_BYTES-1] <= in_ch.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			poll_cnt_q <= '0;
			limit_q    <= cfsd_pkg::POLL_LIMIT_RESET;
		end else begin
			if (cfg.valid && cfg.ready) begin
				limit_q <= cfg.data;
			end
			if (accept) begin
				if (is_byte) begin
					poll_cnt_q <= '0;
					if (match) begin
						fill_q <= '0;
					end else if (fill_q != cfsd_pkg::FILL_FULL) begin
						fill_q <= fill_q + 1'b1;
					end
				end else begin
					poll_cnt_q <= timeout ? '0 : poll_inc;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/cfsd_queue.sv -----
// cfsd_queue: small flop-based FIFO of results between front and back.
// Uses cfsd_pkg.
`default_nettype none

module cfsd_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire cfsd_pkg::result_t push_data,
	input  wire logic              pop,
	output cfsd_pkg::result_t      head,
	output logic                   empty,
	output logic                   full
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cfsd_pkg::result_t  mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/cfsd_back.sv -----
// cfsd_back: output register that drains the result queue onto the result
// channel. Uses cfsd_pkg, cfsd_out_if.
`default_nettype none

module cfsd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_empty,
	input  wire cfsd_pkg::result_t q_head,
	output logic                   pop,
	cfsd_out_if.source             out_ch
);

	logic              valid_q;
	cfsd_pkg::result_t data_q;

	assign pop = !q_empty && (!valid_q || out_ch.ready);

	assign out_ch.valid         = valid_q;
	assign out_ch.result_kind   = data_q.result_kind;
	assign out_ch.frame_command = data_q.frame_command;
	assign out_ch.frame_value   = data_q.frame_value;
	assign out_ch.frame_epoch   = data_q.frame_epoch;
	assign out_ch.frame_ticks   = data_q.frame_ticks;

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/checksum_frame_sync_decoder_unit.sv -----
// checksum_frame_sync_decoder_unit: 9-byte additive-checksum frame hunter.
// Path: each result passes the result queue, then the output register behind out_ch.
// Throughput: one input transaction per cycle; input stalls only on a full result queue.
// Reset: window empty, poll counter zero, poll limit 1000, result queue empty.
// Uses cfsd_pkg, cfsd_in_if, cfsd_out_if, cfsd_cfg_if, cfsd_front, cfsd_queue, cfsd_back.
`default_nettype none

module checksum_frame_sync_decoder_unit #(
	parameter int unsigned QUEUE_DEPTH = 2   // 2..32 results buffered
) (
	input  wire logic clk,
	input  wire logic arst_n,
	cfsd_in_if.sink   in_ch,
	cfsd_out_if.source out_ch,
	cfsd_cfg_if.sink  cfg
);

	// Front: decodes each transaction in its acceptance cycle. A byte shifts
	// into the eight-byte window; with eight bytes held, the new byte is the
	// checksum byte of a candidate frame. On a match the frame is queued and
	// the window restarts, otherwise the oldest byte simply ages out.
	// An idle poll bumps the counter and queues a timeout past the limit.
	logic              q_full;
	logic              q_empty;
	logic              push;
	logic              pop;
	cfsd_pkg::result_t push_data;
	cfsd_pkg::result_t q_head;

	cfsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg       (cfg),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	// Queue: decouples decode from the output stall; input stalls only
	// when it is full.
	cfsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full)
	);

	// Back: registered output stage feeding the result channel.
	cfsd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (q_head),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

`default_nettype wire
